@@ rtl/ilir_pkg.sv @@
`default_nettype none

package ilir_pkg;

    // Operation codes carried in the input tuser
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_POP    = 2'd3;

    // Result status codes carried in the output tuser
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Fixed field widths of the stream beats
    localparam int OP_W       = 2;
    localparam int POS_W      = 7;
    localparam int ITEM_IN_W  = 32;
    localparam int ITEM_OUT_W = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    // Cells per first-level group of the readout tree
    localparam int GROUP = 8;

    // Shift command shared by every cell of the chain
    typedef struct packed {
        logic ins;  // open a slot at the index, shift later entries up
        logic rem;  // close the slot at the index, shift later entries down
    } t_shift_ctrl;

endpackage

`default_nettype wire

@@ rtl/ilir_cell.sv @@
`default_nettype none

module ilir_cell #(
    parameter int INDEX      = 0,
    parameter int IW         = 6,
    parameter int ITEM_WIDTH = 32
) (
    input  wire                      i_clk,
    input  ilir_pkg::t_shift_ctrl    i_ctrl,
    input  wire  [IW-1:0]            i_idx,
    input  wire  [ITEM_WIDTH-1:0]    i_item,
    input  wire  [ITEM_WIDTH-1:0]    i_below,
    input  wire  [ITEM_WIDTH-1:0]    i_above,
    output logic [ITEM_WIDTH-1:0]    o_data
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [ITEM_WIDTH-1:0] r_data;
    logic [ITEM_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (i_idx == MY_IDX) begin
                n_data = i_item;
            end else if (i_idx < MY_IDX) begin
                n_data = i_below;
            end
        end else if (i_ctrl.rem) begin
            if (i_idx <= MY_IDX) begin
                n_data = i_above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

@@ rtl/ilir_gather.sv @@
`default_nettype none

module ilir_gather #(
    parameter int CAPACITY   = 64,
    parameter int IW         = 6,
    parameter int ITEM_WIDTH = 32
) (
    input  wire                    i_clk,
    input  wire                    i_load,
    input  wire                    i_take,
    input  wire  [IW-1:0]          i_idx,
    input  wire  [ITEM_WIDTH-1:0]  i_cells [CAPACITY],
    output logic [ITEM_WIDTH-1:0]  o_item
);

    localparam int GRP    = ilir_pkg::GROUP;
    localparam int GROUPS = (CAPACITY + GRP - 1) / GRP;

    logic [ITEM_WIDTH-1:0] w_gated [GROUPS*GRP];
    logic [ITEM_WIDTH-1:0] n_grp   [GROUPS];
    logic [ITEM_WIDTH-1:0] r_grp   [GROUPS];

    // Mask every cell but the addressed one
    for (genvar k = 0; k < GROUPS*GRP; k++) begin : g_gate
        if (k < CAPACITY) begin : g_real
            assign w_gated[k] = (i_take && i_idx == IW'(k)) ? i_cells[k] : '0;
        end else begin : g_pad
            assign w_gated[k] = '0;
        end
    end

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GRP; j++) begin
                n_grp[g] = n_grp[g] | w_gated[g*GRP + j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= n_grp;
        end
    end

    always_comb begin
        o_item = '0;
        for (int g = 0; g < GROUPS; g++) begin
            o_item = o_item | r_grp[g];
        end
    end

endmodule

`default_nettype wire

@@ rtl/indexed_list_insert_remove_top.sv @@
`default_nettype none

// Bounded ordered list held in a chain of CAPACITY cells. Each input beat
// carries one operation (append, insert at position, remove at position,
// pop last) and yields exactly one result beat with the returned item, a
// status and the entry count after the operation. One operation is taken
// every clock unless back-pressure fills both stages: the whole chain shifts
// up or down on the accepting edge, so the next operation already sees the
// new list. Results pass through the stage 1 and output registers; the
// readout tree's first level of eight-cell OR groups is registered at
// accept and its second level feeds the output register. Cells are not
// cleared at reset; only the fill count and valid flags are, so the block
// is ready right after reset with no clearing pass. Status codes: 0 ok, 1
// position out of range or list empty, 2 list full. A full list rejects
// insert before the position is checked; insert at a position equal to the count appends.
module indexed_list_insert_remove_top #(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Request stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [39:0] i_s_tdata,   // [6:0] position, [38:7] item_in, [39] zero pad
    input  wire  [1:0]  i_s_tuser,   // [1:0] op
    // Result stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] item_out, [38:32] count, [39] zero pad
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int FW   = $clog2(CAPACITY + 1);
    localparam int CW   = (FW > ilir_pkg::POS_W) ? FW : ilir_pkg::POS_W;
    localparam int PW   = ilir_pkg::POS_W;
    localparam int IIW  = ilir_pkg::ITEM_IN_W;
    localparam int IOW  = ilir_pkg::ITEM_OUT_W;
    localparam int CNW  = ilir_pkg::COUNT_W;
    localparam logic [FW-1:0] CAP_F = FW'(CAPACITY);

    // Unpack the request beat
    logic [1:0]            w_op;
    logic [PW-1:0]         w_pos;
    logic [IIW-1:0]        w_item_in;
    logic [ITEM_WIDTH-1:0] w_item;

    assign w_op      = i_s_tuser;
    assign w_pos     = i_s_tdata[PW-1:0];
    assign w_item_in = i_s_tdata[PW+IIW-1:PW];
    assign w_item    = ITEM_WIDTH'(w_item_in);

    // Handshake and pipeline control
    logic r_s1_valid;
    logic r_out_valid;
    logic w_s1_adv;
    logic w_acc;

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || w_s1_adv;
    assign w_acc      = i_s_tvalid && o_s_tready;

    // Decode against the current fill
    logic [FW-1:0] r_fill;
    logic [FW-1:0] dec_fill;
    logic [IW-1:0] dec_idx;
    logic [1:0]    dec_status;
    logic          dec_ins;
    logic          dec_rem;
    logic [CW-1:0] w_pos_c;
    logic [CW-1:0] w_fill_c;
    logic          w_full;
    logic          w_empty;

    assign w_pos_c  = CW'(w_pos);
    assign w_fill_c = CW'(r_fill);
    assign w_full   = (r_fill == CAP_F);
    assign w_empty  = (r_fill == '0);

    always_comb begin
        dec_ins    = 1'b0;
        dec_rem    = 1'b0;
        dec_idx    = IW'(r_fill);
        dec_status = ilir_pkg::ST_OK;
        dec_fill   = r_fill;
        case (w_op)
            ilir_pkg::OP_APPEND: begin
                if (w_full) begin
                    dec_status = ilir_pkg::ST_FULL;
                end else begin
                    dec_ins  = 1'b1;
                    dec_idx  = IW'(r_fill);
                    dec_fill = r_fill + 1'b1;
                end
            end
            ilir_pkg::OP_INSERT: begin
                if (w_full) begin
                    dec_status = ilir_pkg::ST_FULL;
                end else if (w_pos_c > w_fill_c) begin
                    dec_status = ilir_pkg::ST_RANGE;
                end else begin
                    dec_ins  = 1'b1;
                    dec_idx  = IW'(w_pos_c);
                    dec_fill = r_fill + 1'b1;
                end
            end
            ilir_pkg::OP_REMOVE: begin
                if (w_pos_c >= w_fill_c) begin
                    dec_status = ilir_pkg::ST_RANGE;
                end else begin
                    dec_rem  = 1'b1;
                    dec_idx  = IW'(w_pos_c);
                    dec_fill = r_fill - 1'b1;
                end
            end
            ilir_pkg::OP_POP: begin
                if (w_empty) begin
                    dec_status = ilir_pkg::ST_RANGE;
                end else begin
                    dec_rem  = 1'b1;
                    dec_idx  = IW'(r_fill - 1'b1);
                    dec_fill = r_fill - 1'b1;
                end
            end
            default: begin
                dec_status = ilir_pkg::ST_RANGE;
            end
        endcase
    end

    // Shift command: act only on the accepting edge
    ilir_pkg::t_shift_ctrl w_ctrl;
    assign w_ctrl.ins = w_acc && dec_ins;
    assign w_ctrl.rem = w_acc && dec_rem;

    // The cell chain
    logic [ITEM_WIDTH-1:0] w_cell [CAPACITY];

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [ITEM_WIDTH-1:0] w_below;
        logic [ITEM_WIDTH-1:0] w_above;
        if (k == 0) begin : g_first
            assign w_below = '0;
        end else begin : g_mid_lo
            assign w_below = w_cell[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_above = '0;
        end else begin : g_mid_hi
            assign w_above = w_cell[k+1];
        end
        ilir_cell #(
            .INDEX      (k),
            .IW         (IW),
            .ITEM_WIDTH (ITEM_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_idx   (dec_idx),
            .i_item  (w_item),
            .i_below (w_below),
            .i_above (w_above),
            .o_data  (w_cell[k])
        );
    end

    // Readout of the removed entry, captured before the chain shifts
    logic [ITEM_WIDTH-1:0] w_taken;

    ilir_gather #(
        .CAPACITY   (CAPACITY),
        .IW         (IW),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_gather (
        .i_clk   (i_clk),
        .i_load  (w_acc),
        .i_take  (dec_rem),
        .i_idx   (dec_idx),
        .i_cells (w_cell),
        .o_item  (w_taken)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_fill <= dec_fill;
            end
            if (o_s_tready) begin
                r_s1_valid <= w_acc;
            end
            if (!r_out_valid || i_m_tready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers: hold stage 1 until it advances into the output
    logic [1:0]     r_s1_status;
    logic [CNW-1:0] r_s1_count;
    logic [IOW-1:0] r_out_item;
    logic [1:0]     r_out_status;
    logic [CNW-1:0] r_out_count;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_status <= dec_status;
            r_s1_count  <= CNW'(dec_fill);
        end
        if (w_s1_adv) begin
            r_out_item   <= IOW'(w_taken);
            r_out_status <= r_s1_status;
            r_out_count  <= r_s1_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_count, r_out_item};
    assign o_m_tuser  = r_out_status;

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CAP_F)
        else $error("fill count beyond capacity");

    a_rem_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && dec_rem) |=> (r_fill == $past(r_fill) - 1'b1))
        else $error("remove did not shrink the list by one");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ilir_pkg::ST_FULL)
            |-> (o_m_tdata[38:32] == CNW'(CAPACITY) && o_m_tdata[31:0] == '0))
        else $error("full status with wrong count or nonzero item");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("request taken while both stages are stalled");

endmodule

`default_nettype wire
